// File: design/tsc_pkg.sv
// package for trajectory smoothing correction: constants, lane indexes and sequencer states
package tsc_pkg;

  // defaults for the top-level parameters
  localparam int HALF_WINDOW_DEF = 30;
  localparam int TRAJ_WIDTH_DEF  = 40;

  // field widths
  localparam int DX_W    = 24;
  localparam int DY_W    = 24;
  localparam int ANGLE_W = 20;
  localparam int OUT_W   = 32;

  // channel lanes
  localparam int NUM_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_A    = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_CHECK,
    S_READ,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// File: design/tsc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tsc_div.sv
// iterative restoring divider, one quotient bit per cycle, several lanes sharing one divisor
module tsc_div #(
  parameter int LANES = 3,
  parameter int DVD_W = 46,
  parameter int DVS_W = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [LANES-1:0][DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]             divisor_i,
  output logic                         done_o,
  output logic [LANES-1:0][DVD_W-1:0]  quotient_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [DVS_W-1:0]            dvs_q, dvs_d;
  logic [LANES-1:0][DVD_W-1:0] quo_q, quo_d;
  logic [LANES-1:0][DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]              rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    rem_sh = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W);
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int l = 0; l < LANES; l++) begin
        rem_sh = {rem_q[l], quo_q[l][DVD_W-1]};
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_sh = rem_sh - {1'b0, dvs_q};
          quo_d[l] = {quo_q[l][DVD_W-2:0], 1'b1};
        end else begin
          quo_d[l] = {quo_q[l][DVD_W-2:0], 1'b0};
        end
        rem_d[l] = rem_sh[DVS_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: design/trajectory_smoothing_correction.sv
// top level: centered moving-average trajectory smoothing with per-frame correction output
//
// input channel: one beat per video frame carries the motion estimate (dx, dy, angle), a
// found flag (0 counts as zero motion) and end_of_sequence. output channel: one beat per
// corrected frame, oldest first, with last_out set on the final correction of a sequence.
// corrections lag the input by HALF_WINDOW-1 frames; the frame marked end_of_sequence
// flushes all pending corrections, then the block starts a fresh sequence.
// sequencing: a frame that yields no correction passes through accept, ram write and
// check. each correction then sums the n trajectory entries of its window, n up to
// 2*HALF_WINDOW: the entries are read from the ring ram one per cycle, and the divider
// yields one quotient bit per cycle, before the result goes to the output register.
// reset: trajectory, frame count and ring pointer clear at once; the ring ram itself is
// never cleared, only entries of the running sequence are read.
// stall: a finished correction waits in the output register; the next input beat is
// accepted meanwhile, but a further correction waits until the register is taken.
module trajectory_smoothing_correction #(
  parameter int HALF_WINDOW = tsc_pkg::HALF_WINDOW_DEF,
  parameter int TRAJ_WIDTH  = tsc_pkg::TRAJ_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tsc_pkg::DX_W-1:0]   motion_dx_i,
  input  logic signed [tsc_pkg::DY_W-1:0]   motion_dy_i,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] motion_angle_i,
  input  logic                              found_i,
  input  logic                              end_of_sequence_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tsc_pkg::OUT_W-1:0]  correction_dx_o,
  output logic signed [tsc_pkg::OUT_W-1:0]  correction_dy_o,
  output logic signed [tsc_pkg::OUT_W-1:0]  correction_angle_o,
  output logic                              last_out_o
);

  localparam int WIN    = 2 * HALF_WINDOW;
  localparam int AW     = $clog2(WIN);
  localparam int CNT_W  = $clog2(WIN + 1);
  localparam int PEND_W = $clog2(HALF_WINDOW + 1);
  localparam int SUM_W  = TRAJ_WIDTH + $clog2(WIN);
  localparam int DIFF_W = SUM_W + 2;
  localparam int NL     = tsc_pkg::NUM_LANES;
  localparam int OW     = tsc_pkg::OUT_W;
  localparam int T      = TRAJ_WIDTH;

  // sequencer state
  tsc_pkg::state_e state_q, state_d;

  // sequence state: newest trajectory point, frames seen, oldest uncorrected ring slot
  logic [NL-1:0][T-1:0]     cum_q, cum_d;
  logic [CNT_W-1:0]         fs_q, fs_d;
  logic [AW-1:0]            next_out_q, next_out_d;
  logic [PEND_W-1:0]        pend_q, pend_d;
  logic                     last_q, last_d;
  logic [AW-1:0]            wr_addr_q, wr_addr_d;

  // window sweep
  logic [AW-1:0]            rd_addr_q, rd_addr_d;
  logic [AW-1:0]            rd_addr_dly_q, rd_addr_dly_d;
  logic [AW-1:0]            prev_addr_q, prev_addr_d;
  logic                     have_prev_q, have_prev_d;
  logic [CNT_W-1:0]         issue_cnt_q, issue_cnt_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [NL-1:0][SUM_W-1:0] acc_q, acc_d;
  logic [NL-1:0][T-1:0]     prev_q, prev_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [NL-1:0][OW-1:0]    corr_q, corr_d;
  logic                     last_out_q, last_out_d;

  // ring ram and divider hookup
  logic                     ram_we, ram_re;
  logic [NL-1:0][T-1:0]     ram_wdata, ram_rdata;
  logic                     div_start, div_done;
  logic [NL-1:0][SUM_W-1:0] div_dividend, div_quotient;

  logic                     in_beat, out_load;
  logic [NL-1:0][T:0]       mot_ext;
  logic [T:0]               cum_sum;
  logic [PEND_W-1:0]        pend_now;
  logic [AW:0]              wsum, ssum;
  logic [CNT_W-1:0]         older, back_cnt;
  logic [SUM_W-1:0]         mag;
  logic [DIFF_W-1:0]        qx, avg, prevx, diff;

  tsc_ram #(
    .WIDTH(NL * T),
    .DEPTH(WIN)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  tsc_div #(
    .LANES(NL),
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  assign in_ready_o = (state_q == tsc_pkg::S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign ram_wdata  = cum_q;

  // motion inputs, sign-extended to one bit above the trajectory width
  assign mot_ext[tsc_pkg::LANE_X] = (T + 1)'(motion_dx_i);
  assign mot_ext[tsc_pkg::LANE_Y] = (T + 1)'(motion_dy_i);
  assign mot_ext[tsc_pkg::LANE_A] = (T + 1)'(motion_angle_i);

  // frames still waiting for a correction before this frame is written
  assign pend_now = (fs_q < CNT_W'(HALF_WINDOW - 1)) ? PEND_W'(fs_q) : PEND_W'(HALF_WINDOW - 1);
  assign wsum     = {1'b0, next_out_q} + (AW + 1)'(pend_now);

  // window bounds for the frame in slot next_out_q
  assign older    = fs_q - CNT_W'(pend_q);
  assign back_cnt = (older > CNT_W'(HALF_WINDOW)) ? CNT_W'(HALF_WINDOW) : older;
  assign ssum     = {1'b0, next_out_q} + (AW + 1)'(WIN) - (AW + 1)'(back_cnt);

  // magnitude plus half the divisor gives rounding to nearest, ties away from zero
  always_comb begin
    mag = '0;
    for (int l = 0; l < NL; l++) begin
      mag = acc_q[l][SUM_W-1] ? (~acc_q[l] + 1'b1) : acc_q[l];
      div_dividend[l] = mag + SUM_W'(n_q >> 1);
    end
  end

  assign out_load = (state_q == tsc_pkg::S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    cum_d         = cum_q;
    fs_d          = fs_q;
    next_out_d    = next_out_q;
    pend_d        = pend_q;
    last_d        = last_q;
    wr_addr_d     = wr_addr_q;
    rd_addr_d     = rd_addr_q;
    rd_addr_dly_d = rd_addr_dly_q;
    prev_addr_d   = prev_addr_q;
    have_prev_d   = have_prev_q;
    issue_cnt_d   = issue_cnt_q;
    n_d           = n_q;
    rd_vld_d      = 1'b0;
    acc_d         = acc_q;
    prev_d        = prev_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    corr_d        = corr_q;
    last_out_d    = last_out_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;
    cum_sum       = '0;
    qx            = '0;
    avg           = '0;
    prevx         = '0;
    diff          = '0;

    case (state_q)
      tsc_pkg::S_IDLE: begin
        if (in_beat) begin
          // saturating trajectory update, a miss adds nothing
          if (found_i) begin
            for (int l = 0; l < NL; l++) begin
              cum_sum = {cum_q[l][T-1], cum_q[l]} + mot_ext[l];
              if (cum_sum[T] != cum_sum[T-1]) begin
                cum_d[l] = cum_sum[T] ? {1'b1, {(T - 1){1'b0}}} : {1'b0, {(T - 1){1'b1}}};
              end else begin
                cum_d[l] = cum_sum[T-1:0];
              end
            end
          end
          last_d    = end_of_sequence_i;
          pend_d    = pend_now + 1'b1;
          wr_addr_d = (wsum >= (AW + 1)'(WIN)) ? AW'(wsum - (AW + 1)'(WIN)) : AW'(wsum);
          fs_d      = (fs_q < CNT_W'(WIN)) ? fs_q + 1'b1 : fs_q;
          state_d   = tsc_pkg::S_WRITE;
        end
      end

      tsc_pkg::S_WRITE: begin
        ram_we  = 1'b1;
        state_d = tsc_pkg::S_CHECK;
      end

      tsc_pkg::S_CHECK: begin
        if (pend_q != '0 && (last_q || pend_q == PEND_W'(HALF_WINDOW))) begin
          // set up the sweep over the window of the oldest pending frame
          n_d         = back_cnt + CNT_W'(pend_q);
          issue_cnt_d = back_cnt + CNT_W'(pend_q);
          rd_addr_d   = (ssum >= (AW + 1)'(WIN)) ? AW'(ssum - (AW + 1)'(WIN)) : AW'(ssum);
          prev_addr_d = (next_out_q == '0) ? AW'(WIN - 1) : next_out_q - 1'b1;
          have_prev_d = (back_cnt != '0);
          acc_d       = '0;
          prev_d      = '0;
          state_d     = tsc_pkg::S_READ;
        end else begin
          if (last_q) begin
            // sequence done, back to a fresh trajectory
            cum_d      = '0;
            fs_d       = '0;
            next_out_d = '0;
            pend_d     = '0;
            last_d     = 1'b0;
          end
          state_d = tsc_pkg::S_IDLE;
        end
      end

      tsc_pkg::S_READ: begin
        if (issue_cnt_q != '0) begin
          ram_re      = 1'b1;
          rd_vld_d    = 1'b1;
          issue_cnt_d = issue_cnt_q - 1'b1;
          rd_addr_d   = (rd_addr_q == AW'(WIN - 1)) ? '0 : rd_addr_q + 1'b1;
        end
        rd_addr_dly_d = rd_addr_q;
        if (rd_vld_q) begin
          for (int l = 0; l < NL; l++) begin
            acc_d[l] = acc_q[l] + {{(SUM_W - T){ram_rdata[l][T-1]}}, ram_rdata[l]};
          end
          // entry just before the corrected frame
          if (have_prev_q && rd_addr_dly_q == prev_addr_q) begin
            prev_d = ram_rdata;
          end
        end
        if (issue_cnt_q == '0 && !rd_vld_q) begin
          div_start = 1'b1;
          state_d   = tsc_pkg::S_DIV;
        end
      end

      tsc_pkg::S_DIV: begin
        if (div_done) begin
          state_d = tsc_pkg::S_OUT;
        end
      end

      tsc_pkg::S_OUT: begin
        if (out_load) begin
          for (int l = 0; l < NL; l++) begin
            qx    = DIFF_W'(div_quotient[l]);
            avg   = acc_q[l][SUM_W-1] ? (~qx + 1'b1) : qx;
            prevx = {{(DIFF_W - T){prev_q[l][T-1]}}, prev_q[l]};
            diff  = avg - prevx;
            if ((&diff[DIFF_W-1:OW-1]) || !(|diff[DIFF_W-1:OW-1])) begin
              corr_d[l] = diff[OW-1:0];
            end else begin
              corr_d[l] = diff[DIFF_W-1] ? {1'b1, {(OW - 1){1'b0}}} : {1'b0, {(OW - 1){1'b1}}};
            end
          end
          out_valid_d = 1'b1;
          last_out_d  = last_q && (pend_q == PEND_W'(1));
          pend_d      = pend_q - 1'b1;
          next_out_d  = (next_out_q == AW'(WIN - 1)) ? '0 : next_out_q + 1'b1;
          state_d     = tsc_pkg::S_CHECK;
        end
      end

      default: begin
        state_d = tsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsc_pkg::S_IDLE;
      cum_q       <= '0;
      fs_q        <= '0;
      next_out_q  <= '0;
      pend_q      <= '0;
      last_q      <= 1'b0;
      issue_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cum_q       <= cum_d;
      fs_q        <= fs_d;
      next_out_q  <= next_out_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      issue_cnt_q <= issue_cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q     <= wr_addr_d;
    rd_addr_q     <= rd_addr_d;
    rd_addr_dly_q <= rd_addr_dly_d;
    prev_addr_q   <= prev_addr_d;
    have_prev_q   <= have_prev_d;
    n_q           <= n_d;
    acc_q         <= acc_d;
    prev_q        <= prev_d;
    corr_q        <= corr_d;
    last_out_q    <= last_out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign correction_dx_o    = corr_q[tsc_pkg::LANE_X];
  assign correction_dy_o    = corr_q[tsc_pkg::LANE_Y];
  assign correction_angle_o = corr_q[tsc_pkg::LANE_A];
  assign last_out_o         = last_out_q;

  // frame count never passes the ring depth
  a_fs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_q <= CNT_W'(WIN))
    else $error("frame count beyond ring depth");

  // never more pending frames than half a window
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_W'(HALF_WINDOW))
    else $error("pending frame count beyond half window");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tsc_pkg::S_DIV))
    else $error("divider done outside divide state");

  // a correction is loaded only for a frame that is still pending, and is then presented as valid
  a_load_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (pend_q != '0) ##1 out_valid_q)
    else $error("correction loaded with no pending frame");

endmodule

// File: tb/tb_trajectory_smoothing_correction.sv
// testbench for the trajectory smoothing correction block: directed table, random sequences, predictor
`timescale 1ns / 100ps

module tb_trajectory_smoothing_correction;

  // geometry of the block under test (top-level defaults)
  localparam int HALF   = tsc_pkg::HALF_WINDOW_DEF;
  localparam int DEPTH  = 2 * HALF;
  localparam int TRAJ_W = tsc_pkg::TRAJ_WIDTH_DEF;

  // input field extremes
  localparam longint DX_MAX = (longint'(1) <<< (tsc_pkg::DX_W - 1)) - 1;
  localparam longint DX_MIN = -DX_MAX - 1;
  localparam longint DY_MAX = (longint'(1) <<< (tsc_pkg::DY_W - 1)) - 1;
  localparam longint DY_MIN = -DY_MAX - 1;
  localparam longint ANG_MAX = (longint'(1) <<< (tsc_pkg::ANGLE_W - 1)) - 1;
  localparam longint ANG_MIN = -ANG_MAX - 1;

  // correction extremes
  localparam longint OUT_MAX = (longint'(1) <<< (tsc_pkg::OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  // run shape
  localparam int RANDOM_FRAMES  = 145;
  localparam int CALM_FRAMES    = 40;     // tail of the run with no idling on either side
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic signed [tsc_pkg::OUT_W-1:0] dx;
    logic signed [tsc_pkg::OUT_W-1:0] dy;
    logic signed [tsc_pkg::OUT_W-1:0] ang;
    logic                             last;
  } correction_t;

  typedef struct packed {
    logic signed [tsc_pkg::DX_W-1:0]    dx;
    logic signed [tsc_pkg::DY_W-1:0]    dy;
    logic signed [tsc_pkg::ANGLE_W-1:0] ang;
    logic                               found;
    logic                               eos;
    logic                               typed;   // expected correction typed in below
    correction_t                        want;
  } frame_t;

  logic                               clk_i;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic signed [tsc_pkg::DX_W-1:0]    motion_dx_i = '0;
  logic signed [tsc_pkg::DY_W-1:0]    motion_dy_i = '0;
  logic signed [tsc_pkg::ANGLE_W-1:0] motion_angle_i = '0;
  logic                               found_i = 1'b0;
  logic                               end_of_sequence_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [tsc_pkg::OUT_W-1:0]   correction_dx_o;
  logic signed [tsc_pkg::OUT_W-1:0]   correction_dy_o;
  logic signed [tsc_pkg::OUT_W-1:0]   correction_angle_o;
  logic                               last_out_o;

  frame_t frame_on_bus = '0;   // the beat currently presented, with its typed expectation

  trajectory_smoothing_correction uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .motion_dx_i        (motion_dx_i),
    .motion_dy_i        (motion_dy_i),
    .motion_angle_i     (motion_angle_i),
    .found_i            (found_i),
    .end_of_sequence_i  (end_of_sequence_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .correction_dx_o    (correction_dx_o),
    .correction_dy_o    (correction_dy_o),
    .correction_angle_o (correction_angle_o),
    .last_out_o         (last_out_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------------------
  // smoothing predictor: its own trajectory ring, running trajectory and sequence counters
  // ---------------------------------------------------------------------------------------
  longint      traj_ring [tsc_pkg::NUM_LANES][DEPTH];
  longint      traj_now  [tsc_pkg::NUM_LANES];
  int unsigned frames_in_seq = 0;   // saturates at DEPTH
  int unsigned oldest_slot   = 0;   // ring slot of the oldest frame still owed a correction

  correction_t corrections_due [$];

  int unsigned mismatch_count    = 0;
  int unsigned corrections_seen  = 0;
  int unsigned frames_accepted   = 0;
  int unsigned idle_cycles       = 0;

  // idling controls, set by the stimulus process
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit calm       = 1'b0;

  function automatic longint sat_traj(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (TRAJ_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint lane_motion(frame_t f, int lane);
    case (lane)
      tsc_pkg::LANE_X: return longint'($signed(f.dx));
      tsc_pkg::LANE_Y: return longint'($signed(f.dy));
      default:         return longint'($signed(f.ang));
    endcase
  endfunction

  // centered window average of one lane minus the previous trajectory entry
  function automatic logic signed [tsc_pkg::OUT_W-1:0] lane_correction(int lane,
                                                                       int unsigned pos,
                                                                       int unsigned older,
                                                                       int unsigned newer);
    int unsigned back;
    int unsigned ahead;
    int unsigned first;
    int unsigned j;
    longint      n;
    longint      s;
    longint      avg;
    longint      prev;
    longint      v;
    back  = (older < HALF) ? older : HALF;
    ahead = (newer < HALF - 1) ? newer : HALF - 1;
    first = (pos + DEPTH - back) % DEPTH;
    n     = back + 1 + ahead;
    s     = 0;
    for (j = 0; j < n; j++) s += traj_ring[lane][(first + j) % DEPTH];
    // round to nearest, ties away from zero
    if (s >= 0) avg = (s + n / 2) / n;
    else        avg = -((-s + n / 2) / n);
    prev = (back > 0) ? traj_ring[lane][(pos + DEPTH - 1) % DEPTH] : 0;
    v = avg - prev;
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return tsc_pkg::OUT_W'(v);
  endfunction

  // advance the trajectory by one frame and queue every correction it releases
  function automatic void predict_corrections(frame_t f);
    int unsigned pending;
    int unsigned wslot;
    int unsigned pos;
    correction_t c;
    pending = (frames_in_seq < HALF - 1) ? frames_in_seq : HALF - 1;
    wslot   = (oldest_slot + pending) % DEPTH;
    for (int lane = 0; lane < tsc_pkg::NUM_LANES; lane++) begin
      if (f.found) traj_now[lane] = sat_traj(traj_now[lane] + lane_motion(f, lane));
      traj_ring[lane][wslot] = traj_now[lane];
    end
    if (frames_in_seq < DEPTH) frames_in_seq++;
    pending++;
    // a full window releases one correction; end of sequence drains everything owed
    while (pending > 0 && (f.eos || pending == HALF)) begin
      pos   = oldest_slot;
      c.dx  = lane_correction(tsc_pkg::LANE_X, pos, frames_in_seq - pending, pending - 1);
      c.dy  = lane_correction(tsc_pkg::LANE_Y, pos, frames_in_seq - pending, pending - 1);
      c.ang = lane_correction(tsc_pkg::LANE_A, pos, frames_in_seq - pending, pending - 1);
      pending--;
      c.last = f.eos && (pending == 0);
      oldest_slot = (pos + 1) % DEPTH;
      corrections_due = {corrections_due, (f.typed ? f.want : c)};
    end
    // a new sequence starts from zero motion history
    if (f.eos) begin
      for (int lane = 0; lane < tsc_pkg::NUM_LANES; lane++) traj_now[lane] = 0;
      frames_in_seq = 0;
      oldest_slot   = 0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge, plus the watchdog
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    correction_t exp_c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_corrections(frame_on_bus);
        frames_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        corrections_seen++;
        if (corrections_due.size() == 0) begin
          report_mismatch($sformatf("correction beat %0d with nothing expected",
                                    corrections_seen));
        end else begin
          exp_c = corrections_due.pop_front();
          if (correction_dx_o !== exp_c.dx)
            report_mismatch($sformatf("beat %0d correction_dx got %0d expected %0d",
                                      corrections_seen, correction_dx_o, exp_c.dx));
          if (correction_dy_o !== exp_c.dy)
            report_mismatch($sformatf("beat %0d correction_dy got %0d expected %0d",
                                      corrections_seen, correction_dy_o, exp_c.dy));
          if (correction_angle_o !== exp_c.ang)
            report_mismatch($sformatf("beat %0d correction_angle got %0d expected %0d",
                                      corrections_seen, correction_angle_o, exp_c.ang));
          if (last_out_o !== exp_c.last)
            report_mismatch($sformatf("beat %0d last_out got %b expected %b",
                                      corrections_seen, last_out_o, exp_c.last));
        end
      end
      // the block must move a beat on one side or the other within the limit
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles, %0d corrections outstanding",
                 idle_cycles, corrections_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // receiver: ready in random runs, random stalls while idling is on
  // ---------------------------------------------------------------------------------------
  int unsigned ready_left = 0;

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      if (calm || !rx_idle_en || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        ready_left  <= $urandom_range(1, 12);
      end else begin
        out_ready_i <= 1'b0;
        ready_left  <= $urandom_range(1, 6);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------------------

  // enters and leaves at a falling edge; valid is assigned once per edge
  task automatic send_frame(frame_t f);
    int unsigned gap;
    if (tx_idle_en && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    motion_dx_i       <= f.dx;
    motion_dy_i       <= f.dy;
    motion_angle_i    <= f.ang;
    found_i           <= f.found;
    end_of_sequence_i <= f.eos;
    frame_on_bus      <= f;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // hold the input off until every owed correction has come back
  task automatic drain_corrections();
    in_valid_i <= 1'b0;
    while (corrections_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic frame_t row(longint dx, longint dy, longint ang, bit found, bit eos);
    frame_t f;
    f       = '0;
    f.dx    = tsc_pkg::DX_W'(dx);
    f.dy    = tsc_pkg::DY_W'(dy);
    f.ang   = tsc_pkg::ANGLE_W'(ang);
    f.found = found;
    f.eos   = eos;
    return f;
  endfunction

  // single-frame sequence: the correction is the frame's own trajectory, flagged last
  function automatic frame_t lone_row(longint dx, longint dy, longint ang, bit found,
                                      longint wdx, longint wdy, longint wang);
    frame_t f;
    f           = row(dx, dy, ang, found, 1'b1);
    f.typed     = 1'b1;
    f.want.dx   = tsc_pkg::OUT_W'(wdx);
    f.want.dy   = tsc_pkg::OUT_W'(wdy);
    f.want.ang  = tsc_pkg::OUT_W'(wang);
    f.want.last = 1'b1;
    return f;
  endfunction

  // motion values: extremes, small steps around zero, or anything in range
  function automatic longint pick_motion(int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    case ($urandom_range(0, 7))
      0:       return top;
      1:       return -top - 1;
      2, 3:    return longint'($urandom_range(0, 600)) - 300;
      default: return longint'($urandom_range(0, 32'(2 * top + 1))) - top - 1;
    endcase
  endfunction

  function automatic frame_t random_frame(bit eos);
    return row(pick_motion(tsc_pkg::DX_W), pick_motion(tsc_pkg::DY_W),
               pick_motion(tsc_pkg::ANGLE_W), $urandom_range(0, 9) != 0, eos);
  endfunction

  frame_t directed_tbl [$];

  function automatic void add_row(frame_t f);
    directed_tbl = {directed_tbl, f};
  endfunction

  initial begin
    int unsigned rnd_sent;
    int unsigned seq_len;
    int unsigned seq_count;
    int unsigned miss_count;
    int unsigned longest_seq;
    bit          first_seq;
    frame_t      f;

    rnd_sent    = 0;
    seq_count   = 0;
    miss_count  = 0;
    longest_seq = 0;
    first_seq   = 1'b1;
    for (int lane = 0; lane < tsc_pkg::NUM_LANES; lane++) traj_now[lane] = 0;

    // reset held low from the start, released between edges
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-frame sequences: field extremes, miss with nonzero payload, zero, minus one
    add_row(lone_row(DX_MAX, DY_MIN, ANG_MAX, 1'b1, DX_MAX, DY_MIN, ANG_MAX));
    add_row(lone_row(DX_MIN, DY_MAX, ANG_MIN, 1'b1, DX_MIN, DY_MAX, ANG_MIN));
    add_row(lone_row(DX_MAX, DY_MAX, ANG_MAX, 1'b0, 0, 0, 0));
    add_row(lone_row(0, 0, 0, 1'b1, 0, 0, 0));
    add_row(lone_row(-1, -1, -1, 1'b1, -1, -1, -1));
    // short sequence opening on a miss, swinging between the extremes
    add_row(row(DX_MAX, DY_MAX, ANG_MAX, 1'b0, 1'b0));
    add_row(row(DX_MAX, DY_MAX, ANG_MAX, 1'b1, 1'b0));
    add_row(row(DX_MIN, DY_MIN, ANG_MIN, 1'b1, 1'b0));
    add_row(row(24'h555555, 24'haaaaaa, 20'h55555, 1'b1, 1'b0));
    add_row(row(DX_MIN, DY_MAX, ANG_MIN, 1'b0, 1'b0));
    add_row(row(3, -5, 7, 1'b1, 1'b0));
    add_row(row(-24'h2aaaab, 24'h155555, -20'h2aaab, 1'b1, 1'b1));
    // end of sequence carried by a miss
    add_row(row(100, -100, 50, 1'b1, 1'b0));
    add_row(row(-33, 77, -9, 1'b1, 1'b0));
    add_row(row(DX_MAX, DY_MIN, ANG_MAX, 1'b0, 1'b1));
    // two-frame sequences; in the first the dx and dy window averages land on exact halves, both signs
    add_row(row(-1, 1, -1, 1'b1, 1'b0));
    add_row(row(-1, 1, -2, 1'b1, 1'b1));
    add_row(row(1, -3, 5, 1'b1, 1'b0));
    add_row(row(0, 0, 0, 1'b1, 1'b1));

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (directed_tbl[i]) begin
      send_frame(directed_tbl[i]);
      if (!directed_tbl[i].found) miss_count++;
      if (directed_tbl[i].eos) seq_count++;
    end
    drain_corrections();

    // random sequences; the first one is long enough to wrap the trajectory ring
    while (rnd_sent < RANDOM_FRAMES) begin
      if (first_seq) seq_len = 75;
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2: seq_len = $urandom_range(1, 6);
          3, 4, 5: seq_len = $urandom_range(HALF - 2, HALF + 2);
          6, 7, 8: seq_len = $urandom_range(HALF + 3, 50);
          default: seq_len = $urandom_range(DEPTH + 1, 80);
        endcase
      end
      if (seq_len > RANDOM_FRAMES - rnd_sent) seq_len = RANDOM_FRAMES - rnd_sent;
      if (seq_len > longest_seq) longest_seq = seq_len;
      // some sequences run with no idling at all
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      for (int k = 0; k < seq_len; k++) begin
        if (rnd_sent >= RANDOM_FRAMES - CALM_FRAMES) calm = 1'b1;
        f = random_frame(k == seq_len - 1);
        if (!f.found) miss_count++;
        send_frame(f);
        rnd_sent++;
      end
      seq_count++;
      if (!calm && $urandom_range(0, 2) == 0) drain_corrections();
      first_seq = 1'b0;
    end
    in_valid_i <= 1'b0;

    // wait for every owed correction, then give the block time to show any stray beat
    while (corrections_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d frames (%0d misses) in %0d sequences, longest %0d frames",
             frames_accepted, miss_count, seq_count, longest_seq);
    $display("%0d corrections compared, %0d mismatches", corrections_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
